// ===== rtl/dfm_pkg.sv =====
package dfm_pkg;

	// fixed point layout
	localparam int FRAC_BITS = 16;
	localparam int LOG_BITS  = 24;
	localparam int LW        = 40;
	localparam int OUT_W     = 48;
	localparam int LCNT_W    = $clog2(LOG_BITS + 1);
	localparam int ROOT_STEPS = 32;
	localparam int RCNT_W    = $clog2(ROOT_STEPS);

	localparam logic signed [LW-1:0] LOG_ONE = LW'(1) << LOG_BITS;

	// unit factors
	localparam logic [31:0] K_1E9   = 32'd1000000000;
	localparam logic [31:0] K_1E6   = 32'd1000000;
	localparam logic [31:0] K_60    = 32'd60;
	localparam logic [31:0] K_1E4   = 32'd10000;

	// register indexes
	localparam logic [2:0] REG_RPM    = 3'd0;
	localparam logic [2:0] REG_DIA    = 3'd1;
	localparam logic [2:0] REG_SIN    = 3'd2;
	localparam logic [2:0] REG_RAKE   = 3'd3;
	localparam logic [2:0] REG_KC1    = 3'd4;
	localparam logic [2:0] REG_M0     = 3'd5;
	localparam logic [2:0] REG_TOP    = 3'd6;
	localparam logic [2:0] REG_BOTTOM = 3'd7;

	typedef struct packed {
		logic        [15:0] rpm;
		logic        [15:0] dia;
		logic        [15:0] sin_q15;
		logic signed [14:0] rake;
		logic        [15:0] kc1;
		logic        [15:0] m0;
		logic signed [31:0] plate_top;
		logic signed [31:0] plate_bottom;
	} cfg_t;

	typedef struct packed {
		logic        [31:0] vel;
		logic               zero;
	} job_t;

	typedef struct packed {
		logic        start;
		logic [31:0] x;
	} log_req_t;

	typedef struct packed {
		logic                 done;
		logic signed [LW-1:0] l;
	} log_rsp_t;

	typedef struct packed {
		logic                 start;
		logic signed [LW-1:0] l;
	} exp_req_t;

	typedef struct packed {
		logic             done;
		logic [OUT_W-1:0] v;
	} exp_rsp_t;

endpackage

// ===== rtl/dfm_front.sv =====
module dfm_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               req_type,
	input  logic signed [31:0] position_um,
	input  logic signed [31:0] feed_velocity_nmps,
	input  dfm_pkg::cfg_t      cfg,
	output logic               full,
	input  logic               deq,
	output logic               job_valid,
	output dfm_pkg::job_t      job
);
	import dfm_pkg::*;

	logic signed [31:0] depth_q;
	job_t               q_mem_q [2];
	logic               wr_q;
	logic               rd_q;
	logic [1:0]         cnt_q;
	logic               take;
	logic               put;
	job_t               nj;

	assign full      = (cnt_q == 2'd2);
	assign take      = push && !full;
	assign put       = take && req_type;
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_mem_q[rd_q];

	// classify velocity words against the present depth
	always_comb begin
		nj.vel  = feed_velocity_nmps;
		nj.zero = (cfg.rpm == 16'd0) || (feed_velocity_nmps <= 32'sd0) ||
			(depth_q > cfg.plate_top) || (cfg.plate_bottom > depth_q);
	end

	// depth register and job queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (take && !req_type) begin
				depth_q <= 32'sd0 - position_um;
			end
			if (put) begin
				wr_q <= !wr_q;
			end
			if (deq && job_valid) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(put) - 2'(deq && job_valid);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (put) begin
			q_mem_q[wr_q] <= nj;
		end
	end

endmodule

// ===== rtl/dfm_log2.sv =====
module dfm_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  dfm_pkg::log_req_t req,
	output dfm_pkg::log_rsp_t rsp
);
	import dfm_pkg::*;

	logic              run_q;
	logic              done_q;
	logic [LCNT_W-1:0] cnt_q;
	logic [31:0]       m_q;
	logic [LOG_BITS-1:0] frac_q;
	logic [4:0]        e_q;
	logic              zero_q;
	logic [31:0]       nm;
	logic [4:0]        lz;
	logic [63:0]       sq;
	logic [32:0]       sh;

	// leading one search in five steps
	always_comb begin
		nm = req.x;
		lz = '0;
		if (nm[31:16] == 16'd0) begin nm = nm << 16; lz[4] = 1'b1; end
		if (nm[31:24] == 8'd0)  begin nm = nm << 8;  lz[3] = 1'b1; end
		if (nm[31:28] == 4'd0)  begin nm = nm << 4;  lz[2] = 1'b1; end
		if (nm[31:30] == 2'd0)  begin nm = nm << 2;  lz[1] = 1'b1; end
		if (nm[31] == 1'b0)     begin nm = nm << 1;  lz[0] = 1'b1; end
	end

	// one squaring per cycle
	assign sq = 64'(m_q) * 64'(m_q);
	assign sh = sq[63:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= LCNT_W'(LOG_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == LCNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// mantissa and fraction
	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q    <= nm;
			e_q    <= 5'd31 - lz;
			frac_q <= '0;
			zero_q <= (req.x == 32'd0);
		end else if (run_q) begin
			if (sh[32]) begin
				m_q    <= sh[32:1];
				frac_q <= {frac_q[LOG_BITS-2:0], 1'b1};
			end else begin
				m_q    <= sh[31:0];
				frac_q <= {frac_q[LOG_BITS-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.l    = zero_q ? '0 : LW'({e_q, frac_q});

endmodule

// ===== rtl/dfm_exp2.sv =====
module dfm_exp2 (
	input  logic              clk,
	input  logic              arst_n,
	input  dfm_pkg::exp_req_t req,
	output dfm_pkg::exp_rsp_t rsp
);
	import dfm_pkg::*;

	typedef enum logic [4:0] {
		X_IDLE = 5'b00001,
		X_LOAD = 5'b00010,
		X_ROOT = 5'b00100,
		X_FIN  = 5'b01000,
		X_DONE = 5'b10000
	} xst_t;

	localparam logic signed [LW-1:0] T_OFF = LW'(FRAC_BITS) << LOG_BITS;
	localparam logic signed [LW-1:0] T_SAT = LW'(OUT_W) << LOG_BITS;
	localparam int IP_W = LW - LOG_BITS;

	xst_t                  st_q;
	logic signed [LW-1:0]  t;
	logic signed [IP_W-1:0] ip;
	logic signed [IP_W-1:0] ip_q;
	logic [LOG_BITS-1:0]   f_q;
	logic [LCNT_W-1:0]     k_q;
	logic [RCNT_W-1:0]     step_q;
	logic [32:0]           v_q;
	logic [32:0]           vv;
	logic [63:0]           x_q;
	logic [63:0]           r_q;
	logic [63:0]           bit_q;
	logic [64:0]           sum;
	logic                  ge;
	logic [63:0]           r_nx;
	logic [OUT_W-1:0]      res_q;
	logic [4:0]            lsh;
	logic [5:0]            rsh;

	assign t   = req.l + T_OFF;
	assign ip  = t[LW-1:LOG_BITS];
	assign vv  = f_q[k_q] ? (v_q << 1) : v_q;

	// one square root digit per cycle
	assign sum  = 65'(r_q) + 65'(bit_q);
	assign ge   = 65'(x_q) >= sum;
	assign r_nx = ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
	assign lsh  = 5'(ip_q - IP_W'(31));
	assign rsh  = 6'(IP_W'(31) - ip_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= X_IDLE;
		end else begin
			unique case (st_q)
				X_IDLE: begin
					if (req.start) begin
						if (t >= T_SAT || ip < -IP_W'(32)) begin
							st_q <= X_DONE;
						end else begin
							st_q <= X_LOAD;
						end
					end
				end
				X_LOAD: st_q <= X_ROOT;
				X_ROOT: begin
					if (step_q == RCNT_W'(ROOT_STEPS - 1)) begin
						st_q <= (k_q == LCNT_W'(LOG_BITS - 1)) ? X_FIN : X_LOAD;
					end
				end
				X_FIN:  st_q <= X_DONE;
				X_DONE: st_q <= X_IDLE;
				default: st_q <= X_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			X_IDLE: begin
				ip_q <= ip;
				f_q  <= t[LOG_BITS-1:0];
				v_q  <= 33'd1 << 31;
				k_q  <= '0;
				res_q <= (t >= T_SAT) ? {OUT_W{1'b1}} : '0;
			end
			X_LOAD: begin
				x_q    <= {vv, 31'd0};
				r_q    <= '0;
				bit_q  <= 64'd1 << 62;
				step_q <= '0;
			end
			X_ROOT: begin
				if (ge) begin
					x_q <= 64'(65'(x_q) - sum);
				end
				r_q    <= r_nx;
				bit_q  <= bit_q >> 2;
				step_q <= step_q + 1'b1;
				if (step_q == RCNT_W'(ROOT_STEPS - 1)) begin
					v_q <= {1'b0, r_nx[31:0]};
					k_q <= k_q + 1'b1;
				end
			end
			X_FIN: begin
				if (ip_q >= IP_W'(31)) begin
					res_q <= {16'd0, v_q[31:0]} << lsh;
				end else begin
					res_q <= OUT_W'(v_q[31:0] >> rsh);
				end
			end
			default: ;
		endcase
	end

	assign rsp.done = (st_q == X_DONE);
	assign rsp.v    = res_q;

endmodule

// ===== rtl/dfm_back.sv =====
module dfm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfm_pkg::cfg_t               cfg,
	input  logic                        job_valid,
	input  dfm_pkg::job_t               job,
	output logic                        deq,
	output logic                        out_valid,
	input  logic                        out_take,
	output logic [dfm_pkg::OUT_W-1:0]   thrust_force,
	output logic [dfm_pkg::OUT_W-1:0]   cutting_force,
	output logic [dfm_pkg::OUT_W-1:0]   spindle_torque
);
	import dfm_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_LOG  = 10'b0000000010,
		S_LOGW = 10'b0000000100,
		S_SUM  = 10'b0000001000,
		S_MUL  = 10'b0000010000,
		S_KC   = 10'b0000100000,
		S_ARG  = 10'b0001000000,
		S_EXP  = 10'b0010000000,
		S_EXPW = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} st_t;

	// log slots
	localparam logic [3:0] L_VEL = 4'd0;
	localparam logic [3:0] L_E9  = 4'd1;
	localparam logic [3:0] L_DIA = 4'd2;
	localparam logic [3:0] L_E6  = 4'd3;
	localparam logic [3:0] L_RPM = 4'd4;
	localparam logic [3:0] L_SIN = 4'd5;
	localparam logic [3:0] L_60  = 4'd6;
	localparam logic [3:0] L_KC1 = 4'd7;
	localparam logic [3:0] L_CN  = 4'd8;
	localparam logic [3:0] L_E4  = 4'd9;

	st_t                  st_q;
	logic [3:0]           li_q;
	logic [1:0]           oi_q;
	logic [31:0]          vel_q;
	logic signed [LW-1:0] lg_q [10];
	logic signed [LW-1:0] lv_q, ld_q, ln_q, lh_q, e_q, lkc_q, arg_q;
	logic [OUT_W-1:0]     res_q [3];
	logic                 out_valid_q;
	logic signed [16:0]   cnum;
	logic [15:0]          sin_eff;
	logic signed [LW+16:0] prod;
	logic signed [LW+16:0] prod_sh;
	log_req_t             lreq;
	log_rsp_t             lrsp;
	exp_req_t             xreq;
	exp_rsp_t             xrsp;
	logic                 skip;

	dfm_log2 u_log2 (.clk(clk), .arst_n(arst_n), .req(lreq), .rsp(lrsp));
	dfm_exp2 u_exp2 (.clk(clk), .arst_n(arst_n), .req(xreq), .rsp(xrsp));

	assign cnum    = 17'sd10000 - 17'(cfg.rake);
	assign sin_eff = (cfg.sin_q15 == 16'd0) ? 16'd1 : cfg.sin_q15;
	assign skip    = job.zero || (cnum <= 17'sd0) || (cfg.dia == 16'd0) ||
		(cfg.kc1 == 16'd0);
	assign deq     = (st_q == S_IDLE) && job_valid;
	assign prod    = $signed({1'b0, cfg.m0}) * lh_q;
	assign prod_sh = prod >>> 16;

	// log argument select
	always_comb begin
		lreq.start = (st_q == S_LOG);
		case (li_q)
			L_VEL:   lreq.x = vel_q;
			L_E9:    lreq.x = K_1E9;
			L_DIA:   lreq.x = 32'(cfg.dia);
			L_E6:    lreq.x = K_1E6;
			L_RPM:   lreq.x = 32'(cfg.rpm);
			L_SIN:   lreq.x = 32'(sin_eff);
			L_60:    lreq.x = K_60;
			L_KC1:   lreq.x = 32'(cfg.kc1);
			L_CN:    lreq.x = 32'(cnum[15:0]);
			default: lreq.x = K_1E4;
		endcase
	end

	assign xreq.start = (st_q == S_EXP);
	assign xreq.l     = arg_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_take) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (job_valid) begin
						st_q <= skip ? S_OUT : S_LOG;
					end
				end
				S_LOG:  st_q <= S_LOGW;
				S_LOGW: begin
					if (lrsp.done) begin
						st_q <= (li_q == L_E4) ? S_SUM : S_LOG;
					end
				end
				S_SUM:  st_q <= S_MUL;
				S_MUL:  st_q <= S_KC;
				S_KC:   st_q <= S_ARG;
				S_ARG: begin
					if (!(oi_q == 2'd0 && cfg.sin_q15 == 16'd0)) begin
						st_q <= S_EXP;
					end
				end
				S_EXP:  st_q <= S_EXPW;
				S_EXPW: begin
					if (xrsp.done) begin
						st_q <= (oi_q == 2'd2) ? S_OUT : S_ARG;
					end
				end
				S_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				vel_q <= job.vel;
				li_q  <= '0;
				oi_q  <= '0;
				res_q[0] <= '0;
				res_q[1] <= '0;
				res_q[2] <= '0;
			end
			S_LOGW: begin
				if (lrsp.done) begin
					lg_q[li_q] <= lrsp.l;
					li_q       <= li_q + 1'b1;
				end
			end
			S_SUM: begin
				lv_q <= lg_q[L_VEL] - lg_q[L_E9];
				ld_q <= lg_q[L_DIA] - lg_q[L_E6];
				ln_q <= lg_q[L_RPM];
				lh_q <= lg_q[L_VEL] - lg_q[L_E9] + lg_q[L_SIN] - 15 * LOG_ONE
					- lg_q[L_60] - lg_q[L_RPM];
			end
			S_MUL: e_q <= -LW'(prod_sh);
			S_KC:  lkc_q <= lg_q[L_KC1] + e_q + lg_q[L_CN] - lg_q[L_E4];
			S_ARG: begin
				case (oi_q)
					2'd0: begin
						arg_q <= lkc_q + ld_q + lh_q - LOG_ONE;
						if (cfg.sin_q15 == 16'd0) begin
							oi_q <= 2'd1;
						end
					end
					2'd1:    arg_q <= lv_q + ld_q + lkc_q - ln_q - 2 * LOG_ONE;
					default: arg_q <= lv_q + 2 * ld_q + lkc_q - ln_q - 3 * LOG_ONE;
				endcase
			end
			S_EXPW: begin
				if (xrsp.done) begin
					res_q[oi_q] <= xrsp.v;
					oi_q        <= oi_q + 1'b1;
				end
			end
			S_OUT: begin
				if (!out_valid_q) begin
					thrust_force   <= res_q[0];
					cutting_force  <= res_q[1];
					spindle_torque <= res_q[2];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/drilling_force_model.sv =====
// flow: a velocity word is registered into the job queue, then runs ten log steps
// on one squaring unit and up to three power steps of 24 roots on one bit-serial
// root unit; zero-result words skip these steps
// throughput: the back end takes a new velocity word only when idle; pose words
// are taken each cycle while the two-entry job queue has room
// reset: asynchronous, clears depth, queue and result valid; registers to defaults
module drilling_force_model (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      req_type,
	input  logic signed [31:0]        position_um,
	input  logic signed [31:0]        feed_velocity_nmps,
	output logic                      empty,
	input  logic                      pop,
	output logic [dfm_pkg::OUT_W-1:0] thrust_force,
	output logic [dfm_pkg::OUT_W-1:0] cutting_force,
	output logic [dfm_pkg::OUT_W-1:0] spindle_torque,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [31:0]               cfg_data
);
	import dfm_pkg::*;

	cfg_t cfg_q;
	logic job_valid;
	job_t job;
	logic deq;
	logic out_valid;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rpm          <= 16'd3000;
			cfg_q.dia          <= 16'd6000;
			cfg_q.sin_q15      <= 16'd32768;
			cfg_q.rake         <= 15'sd2500;
			cfg_q.kc1          <= 16'd600;
			cfg_q.m0           <= 16'd13107;
			cfg_q.plate_top    <= -32'sd200000;
			cfg_q.plate_bottom <= -32'sd400000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RPM:    cfg_q.rpm          <= cfg_data[15:0];
				REG_DIA:    cfg_q.dia          <= cfg_data[15:0];
				REG_SIN:    cfg_q.sin_q15      <= cfg_data[15:0];
				REG_RAKE:   cfg_q.rake         <= cfg_data[14:0];
				REG_KC1:    cfg_q.kc1          <= cfg_data[15:0];
				REG_M0:     cfg_q.m0           <= cfg_data[15:0];
				REG_TOP:    cfg_q.plate_top    <= cfg_data;
				REG_BOTTOM: cfg_q.plate_bottom <= cfg_data;
				default: ;
			endcase
		end
	end

	dfm_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.req_type           (req_type),
		.position_um        (position_um),
		.feed_velocity_nmps (feed_velocity_nmps),
		.cfg                (cfg_q),
		.full               (full),
		.deq                (deq),
		.job_valid          (job_valid),
		.job                (job)
	);

	dfm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.job_valid      (job_valid),
		.job            (job),
		.deq            (deq),
		.out_valid      (out_valid),
		.out_take       (pop),
		.thrust_force   (thrust_force),
		.cutting_force  (cutting_force),
		.spindle_torque (spindle_torque)
	);

	assign empty = !out_valid;

endmodule

// ===== rtl/dfm_checker.sv =====
module dfm_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      empty,
	input logic                      pop,
	input logic [dfm_pkg::OUT_W-1:0] thrust_force,
	input logic [dfm_pkg::OUT_W-1:0] cutting_force,
	input logic [dfm_pkg::OUT_W-1:0] spindle_torque
);

	// a waiting word stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped before pop");

	// a waiting word keeps its value
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(thrust_force) && $stable(cutting_force) &&
		$stable(spindle_torque)))
		else $error("result changed while waiting");

	// the single result slot is never refilled in the cycle it is taken
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result slot refilled on pop");

endmodule

bind drilling_force_model dfm_checker u_dfm_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.empty          (empty),
	.pop            (pop),
	.thrust_force   (thrust_force),
	.cutting_force  (cutting_force),
	.spindle_torque (spindle_torque)
);
